// File: design/bcle_pkg.sv
// ----------------------------------------------------------------------------
// bcle_pkg: shared types and constants for the circular list engine
// Opcodes, status codes, controller states, micro-ops and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bcle_pkg;

   localparam int DefCapacity = 64;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_INS_AFTER  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_DELETE     = 3'd5,
      OP_SEARCH     = 3'd6,
      OP_NONE       = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_ALLOC, S_LNK_EMPTY, S_LNK_HEAD,
      S_LNK_TF, S_LNK_TB, S_LNK_AFTER, S_LNK_AT, S_FIND_STEP,
      S_PF_RD, S_PF_RD2, S_PF_FIN, S_PB_STEP, S_PB_FIN, S_DEL_FIN,
      S_GIVE, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      U_NOP, U_CLEAR, U_LOAD, U_RD_FREE, U_LNK_EMPTY, U_LNK_HEAD,
      U_LNK_TF, U_LNK_TB, U_LNK_AFTER, U_LNK_AT, U_FIND_START,
      U_FIND_STEP, U_PF_RD, U_PF_RD2, U_PF_FIN, U_PB_START, U_PB_STEP,
      U_PB_FIN, U_DEL_FIN, U_GIVE
   } uop_type;

   typedef struct packed {
      uop_type    uop;
      logic       st_we;
      status_type st;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       occ_zero;
      logic       occ_one;
      logic       full;
      logic       hit;
      logic       last;
      logic       pb_hit;
      logic       at_head;
      logic       clr_done;
   } dp_status_type;

endpackage
`default_nettype wire

// File: design/bcle_ctrl.sv
// ----------------------------------------------------------------------------
// bcle_ctrl: sequencer for the circular list engine
// Steps each command through allocation, list walks, relinking and release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bcle_ctrl
   import bcle_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   output logic               rsp_valid,
   input  dp_status_type      dp_st,
   output cmd_type            cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.uop   = U_NOP;
      cmd.st_we = 1'b0;
      cmd.st    = ST_OK;
      busy      = (state_ff != S_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.uop = U_CLEAR;
            if (dp_st.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.uop  = U_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (dp_st.op)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (dp_st.full) begin
                     cmd.st_we = 1'b1; cmd.st = ST_FULL; state_in = S_DONE;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
               OP_INS_AFTER: begin
                  if (dp_st.occ_zero) begin
                     state_in = S_ALLOC;
                  end else if (dp_st.full) begin
                     cmd.st_we = 1'b1; cmd.st = ST_FULL; state_in = S_DONE;
                  end else begin
                     cmd.uop = U_FIND_START; state_in = S_FIND_STEP;
                  end
               end
               OP_POP_FRONT: begin
                  if (dp_st.occ_zero) begin
                     cmd.st_we = 1'b1; cmd.st = ST_EMPTY; state_in = S_DONE;
                  end else begin
                     state_in = S_PF_RD;
                  end
               end
               OP_POP_BACK: begin
                  if (dp_st.occ_zero) begin
                     cmd.st_we = 1'b1; cmd.st = ST_EMPTY; state_in = S_DONE;
                  end else if (dp_st.occ_one) begin
                     state_in = S_PF_RD;
                  end else begin
                     cmd.uop = U_PB_START; state_in = S_PB_STEP;
                  end
               end
               OP_DELETE: begin
                  if (dp_st.occ_zero) begin
                     cmd.st_we = 1'b1; cmd.st = ST_EMPTY; state_in = S_DONE;
                  end else begin
                     cmd.uop = U_FIND_START; state_in = S_FIND_STEP;
                  end
               end
               OP_SEARCH: begin
                  if (dp_st.occ_zero) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.uop = U_FIND_START; state_in = S_FIND_STEP;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_ALLOC: begin
            cmd.uop = U_RD_FREE;
            if (dp_st.occ_zero) state_in = S_LNK_EMPTY;
            else if (dp_st.op == OP_INS_AFTER) state_in = S_LNK_AFTER;
            else state_in = S_LNK_HEAD;
         end
         S_LNK_EMPTY: begin
            cmd.uop = U_LNK_EMPTY; state_in = S_DONE;
         end
         S_LNK_HEAD: begin
            cmd.uop  = U_LNK_HEAD;
            state_in = (dp_st.op == OP_PUSH_FRONT) ? S_LNK_TF : S_LNK_TB;
         end
         S_LNK_TF: begin
            cmd.uop = U_LNK_TF; state_in = S_DONE;
         end
         S_LNK_TB: begin
            cmd.uop = U_LNK_TB; state_in = S_DONE;
         end
         S_LNK_AFTER: begin
            cmd.uop = U_LNK_AFTER; state_in = S_LNK_AT;
         end
         S_LNK_AT: begin
            cmd.uop = U_LNK_AT; state_in = S_DONE;
         end
         S_FIND_STEP: begin
            cmd.uop = U_FIND_STEP;
            if (dp_st.hit) begin
               case (dp_st.op)
                  OP_INS_AFTER: state_in = S_ALLOC;
                  OP_DELETE:    state_in = dp_st.at_head ? S_PF_RD : S_DEL_FIN;
                  default:      state_in = S_DONE;
               endcase
            end else if (dp_st.last) begin
               if (dp_st.op != OP_SEARCH) begin
                  cmd.st_we = 1'b1; cmd.st = ST_NOT_FOUND;
               end
               state_in = S_DONE;
            end
         end
         S_PF_RD: begin
            cmd.uop = U_PF_RD; state_in = S_PF_RD2;
         end
         S_PF_RD2: begin
            cmd.uop = U_PF_RD2; state_in = S_PF_FIN;
         end
         S_PF_FIN: begin
            cmd.uop = U_PF_FIN; state_in = S_GIVE;
         end
         S_PB_STEP: begin
            cmd.uop = U_PB_STEP;
            if (dp_st.pb_hit) state_in = S_PB_FIN;
         end
         S_PB_FIN: begin
            cmd.uop = U_PB_FIN; state_in = S_GIVE;
         end
         S_DEL_FIN: begin
            cmd.uop = U_DEL_FIN; state_in = S_GIVE;
         end
         S_GIVE: begin
            cmd.uop = U_GIVE; state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: design/bcle_dp.sv
// ----------------------------------------------------------------------------
// bcle_dp: datapath for the circular list engine
// Node value and link memories, list pointers, walk registers and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bcle_dp
   import bcle_pkg::*;
#(
   parameter int CAPACITY = DefCapacity
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  cmd_type                 cmd,
   output dp_status_type           dp_st,
   input  wire logic        [2:0]  req_opcode,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic signed [31:0] req_point_value,
   output logic             [1:0]  rsp_status,
   output logic signed      [31:0] rsp_removed_value,
   output logic                    rsp_found,
   output logic             [6:0]  rsp_entry_count,
   output logic signed      [31:0] rsp_front_value,
   output logic signed      [31:0] rsp_back_value
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);
   localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);

   logic [31:0] val_mem [CAPACITY];
   logic [IW-1:0] lnk_mem [CAPACITY];

   logic [31:0]   val_rd;
   logic [IW-1:0] lnk_rd;
   logic [IW-1:0] rd_addr;
   logic          val_we, lnk_we;
   logic [IW-1:0] lnk_wa, lnk_wd;

   // control registers
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [IW-1:0] clr_ff, clr_in;
   // walk and payload registers
   logic [IW-1:0] cur_ff, cur_in, prv_ff, prv_in, nxt_ff, nxt_in;
   logic [IW-1:0] nn_ff, nn_in, gv_ff, gv_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   front_ff, front_in, back_ff, back_in, prvv_ff, prvv_in;
   logic [31:0]   item_ff, item_in, point_ff, point_in, key_ff, key_in;
   logic [31:0]   rem_ff, rem_in;
   opcode_type    op_ff, op_in;
   status_type    st_ff, st_in;
   logic          fnd_ff, fnd_in;

   logic hit, pb_hit;

   assign hit    = (val_rd == key_ff);
   assign pb_hit = (lnk_rd == tail_ff);

   assign dp_st.op       = op_ff;
   assign dp_st.occ_zero = (occ_ff == '0);
   assign dp_st.occ_one  = (occ_ff == CW'(1));
   assign dp_st.full     = (occ_ff == CapCnt);
   assign dp_st.hit      = hit;
   assign dp_st.last     = (cnt_ff == CW'(occ_ff - CW'(1)));
   assign dp_st.pb_hit   = pb_hit;
   assign dp_st.at_head  = (cur_ff == head_ff);
   assign dp_st.clr_done = (clr_ff == LastIdx);

   always_ff @(posedge clock) begin
      if (val_we) val_mem[free_ff] <= item_ff;
      if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
      val_rd <= val_mem[rd_addr];
      lnk_rd <= lnk_mem[rd_addr];
   end

   always_comb begin
      head_in = head_ff; tail_in = tail_ff; free_in = free_ff; occ_in = occ_ff;
      clr_in = clr_ff; cur_in = cur_ff; prv_in = prv_ff; nxt_in = nxt_ff;
      nn_in = nn_ff; gv_in = gv_ff; cnt_in = cnt_ff; front_in = front_ff;
      back_in = back_ff; prvv_in = prvv_ff; item_in = item_ff;
      point_in = point_ff; key_in = key_ff; rem_in = rem_ff; op_in = op_ff;
      st_in = cmd.st_we ? cmd.st : st_ff; fnd_in = fnd_ff;
      rd_addr = cur_ff;
      val_we = 1'b0; lnk_we = 1'b0; lnk_wa = nn_ff; lnk_wd = nn_ff;
      case (cmd.uop)
         U_CLEAR: begin
            lnk_we = 1'b1; lnk_wa = clr_ff;
            lnk_wd = (clr_ff == LastIdx) ? '0 : IW'(clr_ff + IW'(1));
            clr_in = IW'(clr_ff + IW'(1));
         end
         U_LOAD: begin
            op_in    = opcode_type'(req_opcode);
            item_in  = req_item_value;
            point_in = req_point_value;
            key_in   = (opcode_type'(req_opcode) == OP_SEARCH) ? req_item_value
                                                               : req_point_value;
            rem_in = '0; st_in = ST_OK; fnd_in = 1'b0;
         end
         U_RD_FREE: begin
            rd_addr = free_ff; nn_in = free_ff; val_we = 1'b1;
         end
         U_LNK_EMPTY: begin
            free_in = lnk_rd; lnk_we = 1'b1; lnk_wa = nn_ff; lnk_wd = nn_ff;
            head_in = nn_ff; tail_in = nn_ff;
            front_in = item_ff; back_in = item_ff;
            occ_in = CW'(occ_ff + CW'(1));
         end
         U_LNK_HEAD: begin
            free_in = lnk_rd; lnk_we = 1'b1; lnk_wa = nn_ff; lnk_wd = head_ff;
         end
         U_LNK_TF: begin
            lnk_we = 1'b1; lnk_wa = tail_ff; lnk_wd = nn_ff;
            head_in = nn_ff; front_in = item_ff;
            occ_in = CW'(occ_ff + CW'(1));
         end
         U_LNK_TB: begin
            lnk_we = 1'b1; lnk_wa = tail_ff; lnk_wd = nn_ff;
            tail_in = nn_ff; back_in = item_ff;
            occ_in = CW'(occ_ff + CW'(1));
         end
         U_LNK_AFTER: begin
            free_in = lnk_rd; lnk_we = 1'b1; lnk_wa = nn_ff; lnk_wd = nxt_ff;
         end
         U_LNK_AT: begin
            lnk_we = 1'b1; lnk_wa = cur_ff; lnk_wd = nn_ff;
            if (cur_ff == tail_ff) begin
               tail_in = nn_ff; back_in = item_ff;
            end
            occ_in = CW'(occ_ff + CW'(1));
         end
         U_FIND_START: begin
            cur_in = head_ff; prv_in = tail_ff; prvv_in = back_ff;
            cnt_in = '0; rd_addr = head_ff;
         end
         U_FIND_STEP: begin
            nxt_in = lnk_rd;
            if (hit) begin
               rd_addr = cur_ff;
               if (op_ff == OP_SEARCH) fnd_in = 1'b1;
            end else begin
               prv_in = cur_ff; prvv_in = val_rd; cur_in = lnk_rd;
               cnt_in = CW'(cnt_ff + CW'(1)); rd_addr = lnk_rd;
            end
         end
         U_PF_RD: begin
            rd_addr = head_ff; gv_in = head_ff;
         end
         U_PF_RD2: begin
            rd_addr = lnk_rd; nxt_in = lnk_rd;
         end
         U_PF_FIN: begin
            rem_in = front_ff;
            lnk_we = 1'b1; lnk_wa = tail_ff; lnk_wd = nxt_ff;
            if (occ_ff == CW'(1)) begin
               head_in = '0; tail_in = '0; occ_in = '0;
            end else begin
               head_in = nxt_ff; front_in = val_rd;
               occ_in = CW'(occ_ff - CW'(1));
            end
         end
         U_PB_START: begin
            cur_in = head_ff; rd_addr = head_ff;
         end
         U_PB_STEP: begin
            // stop when the node links to the back; keep its value on the port
            if (pb_hit) begin
               rd_addr = cur_ff;
            end else begin
               cur_in = lnk_rd; rd_addr = lnk_rd;
            end
         end
         U_PB_FIN: begin
            rem_in = back_ff; gv_in = tail_ff;
            lnk_we = 1'b1; lnk_wa = cur_ff; lnk_wd = head_ff;
            tail_in = cur_ff; back_in = val_rd;
            occ_in = CW'(occ_ff - CW'(1));
         end
         U_DEL_FIN: begin
            rem_in = point_ff; gv_in = cur_ff;
            lnk_we = 1'b1; lnk_wa = prv_ff; lnk_wd = nxt_ff;
            if (cur_ff == tail_ff) begin
               tail_in = prv_ff; back_in = prvv_ff;
            end
            occ_in = CW'(occ_ff - CW'(1));
         end
         U_GIVE: begin
            lnk_we = 1'b1; lnk_wa = gv_ff; lnk_wd = free_ff; free_in = gv_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; tail_ff <= '0; free_ff <= '0; occ_ff <= '0; clr_ff <= '0;
      end else begin
         head_ff <= head_in; tail_ff <= tail_in; free_ff <= free_in;
         occ_ff <= occ_in; clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; prv_ff <= prv_in; nxt_ff <= nxt_in; nn_ff <= nn_in;
      gv_ff <= gv_in; cnt_ff <= cnt_in; front_ff <= front_in; back_ff <= back_in;
      prvv_ff <= prvv_in; item_ff <= item_in; point_ff <= point_in;
      key_ff <= key_in; rem_ff <= rem_in; op_ff <= op_in; st_ff <= st_in;
      fnd_ff <= fnd_in;
   end

   assign rsp_status        = st_ff;
   assign rsp_removed_value = rem_ff;
   assign rsp_found         = fnd_ff;
   assign rsp_entry_count   = 7'(occ_ff);
   assign rsp_front_value   = (occ_ff == '0) ? '0 : front_ff;
   assign rsp_back_value    = (occ_ff == '0) ? '0 : back_ff;

endmodule
`default_nettype wire

// File: design/bounded_circular_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_circular_list_engine: ordered list of 32-bit values in linked nodes
// Top level: controller plus datapath; one command in, one result out.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// for one cycle with rsp_valid and cannot be stalled. Insert-after, delete
// and search walk the list one node per cycle through the single read port
// of the node memories; pop back walks to the node before the back. After
// reset the link memory is chained into the free list while busy stays high.
`timescale 1ns / 1ps
`default_nettype none
module bounded_circular_list_engine
   import bcle_pkg::*;
#(
   parameter int CAPACITY = DefCapacity
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [2:0]  req_opcode,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic signed [31:0] req_point_value,
   output logic                    rsp_valid,
   output logic             [1:0]  rsp_status,
   output logic signed      [31:0] rsp_removed_value,
   output logic                    rsp_found,
   output logic             [6:0]  rsp_entry_count,
   output logic signed      [31:0] rsp_front_value,
   output logic signed      [31:0] rsp_back_value
);

   cmd_type       cmd;
   dp_status_type dp_st;

   bcle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_st     (dp_st),
      .cmd       (cmd)
   );

   bcle_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_st             (dp_st),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_point_value   (req_point_value),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_found         (rsp_found),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value)
   );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: circular list engine check
// Drives list commands through the start/busy handshake, predicts each
// result from a local linked-list model and compares every response field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
   import bcle_pkg::*;

   localparam int Cap = 64;
   localparam int NumRandom = 440;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] removed;
      logic        found;
      logic [6:0]  count;
      logic [31:0] front;
      logic [31:0] back;
   } list_result_type;

   typedef struct {
      opcode_type  op;
      logic [31:0] item;
      logic [31:0] point;
      bit          typed;   // expected result written in the row
      logic [1:0]  status;
      logic [6:0]  count;
   } cmd_row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_opcode = '0;
   logic signed [31:0] req_item_value = '0;
   logic signed [31:0] req_point_value = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_removed_value;
   logic rsp_found;
   logic [6:0] rsp_entry_count;
   logic signed [31:0] rsp_front_value;
   logic signed [31:0] rsp_back_value;

   bounded_circular_list_engine DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] vals [Cap];
   logic [5:0]  links [Cap];
   logic [5:0]  head_n, tail_n, free_n;
   int          occ;

   list_result_type pending_results [$];
   bit           typed_q [$];
   logic [1:0]   typed_status_q [$];
   logic [6:0]   typed_count_q [$];
   int errors = 0;
   int rnd_count = 0;

   function automatic logic [5:0] take_node(logic [31:0] v);
      logic [5:0] n;
      n = free_n;
      free_n = links[n];
      vals[n] = v;
      return n;
   endfunction

   function automatic void give_node(logic [5:0] n);
      links[n] = free_n;
      free_n = n;
   endfunction

   function automatic void add_node(logic [31:0] v, bit at_front);
      logic [5:0] n;
      n = take_node(v);
      if (occ == 0) begin
         head_n = n; tail_n = n; links[n] = n;
      end else begin
         links[n] = head_n;
         links[tail_n] = n;
         if (at_front) head_n = n;
         else tail_n = n;
      end
      occ++;
   endfunction

   function automatic logic [31:0] drop_front();
      logic [5:0] old;
      logic [31:0] v;
      old = head_n;
      v = vals[old];
      if (occ <= 1) begin
         head_n = 0; tail_n = 0; occ = 0;
      end else begin
         head_n = links[old];
         links[tail_n] = head_n;
         occ--;
      end
      give_node(old);
      return v;
   endfunction

   function automatic bit find_node(logic [31:0] v, output logic [5:0] at,
                                    output logic [5:0] prv);
      logic [5:0] p, c;
      p = tail_n; c = head_n; at = 0; prv = 0;
      for (int i = 0; i < occ; i++) begin
         if (vals[c] == v) begin
            at = c; prv = p;
            return 1;
         end
         p = c;
         c = links[c];
      end
      return 0;
   endfunction

   function automatic list_result_type list_apply(opcode_type op, logic [31:0] item,
                                                  logic [31:0] point);
      list_result_type r;
      logic [5:0] at, prv, n, p, t;
      bit full;
      r.status = ST_OK; r.removed = 0; r.found = 0;
      full = occ >= Cap;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) r.status = ST_FULL;
            else add_node(item, op == OP_PUSH_FRONT);
         end
         OP_INS_AFTER: begin
            if (occ == 0) add_node(item, 0);
            else if (full) r.status = ST_FULL;
            else if (!find_node(point, at, prv)) r.status = ST_NOT_FOUND;
            else begin
               n = take_node(item);
               links[n] = links[at];
               links[at] = n;
               if (at == tail_n) tail_n = n;
               occ++;
            end
         end
         OP_POP_FRONT: begin
            if (occ == 0) r.status = ST_EMPTY;
            else r.removed = drop_front();
         end
         OP_POP_BACK: begin
            if (occ == 0) r.status = ST_EMPTY;
            else if (occ == 1) r.removed = drop_front();
            else begin
               p = head_n; t = tail_n;
               for (int i = 0; i < occ && links[p] != t; i++) p = links[p];
               r.removed = vals[t];
               links[p] = head_n;
               tail_n = p;
               occ--;
               give_node(t);
            end
         end
         OP_DELETE: begin
            if (occ == 0) r.status = ST_EMPTY;
            else if (!find_node(point, at, prv)) r.status = ST_NOT_FOUND;
            else if (at == head_n) r.removed = drop_front();
            else begin
               r.removed = vals[at];
               links[prv] = links[at];
               if (at == tail_n) tail_n = prv;
               occ--;
               give_node(at);
            end
         end
         OP_SEARCH: r.found = find_node(item, at, prv);
         default: ;
      endcase
      r.count = occ[6:0];
      r.front = occ ? vals[head_n] : '0;
      r.back  = occ ? vals[tail_n] : '0;
      return r;
   endfunction

   // random value drawn often from the list contents so keys hit
   function automatic logic [31:0] pick_value();
      int k;
      k = $urandom_range(0, 9);
      if (occ > 0 && k < 6) begin
         logic [5:0] c;
         c = head_n;
         repeat ($urandom_range(0, occ - 1)) c = links[c];
         return vals[c];
      end
      if (k == 6) return 32'h8000_0000;
      if (k == 7) return 32'h7FFF_FFFF;
      if (k == 8) return $urandom_range(0, 3);
      return $urandom;
   endfunction

   task automatic send_cmd(opcode_type op, logic [31:0] item, logic [31:0] point,
                           bit typed, logic [1:0] st, logic [6:0] cnt);
      int gap;
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      repeat (gap) @(negedge clock);
      start <= 1;
      req_opcode <= op;
      req_item_value <= item;
      req_point_value <= point;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      pending_results.push_back(list_apply(op, item, point));
      typed_q.push_back(typed);
      typed_status_q.push_back(st);
      typed_count_q.push_back(cnt);
      @(negedge clock);
      start <= 0;
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat status=%0d", $time, rsp_status);
            errors++;
         end else begin
            list_result_type e;
            bit ty;
            logic [1:0] ts;
            logic [6:0] tc;
            e = pending_results.pop_front();
            ty = typed_q.pop_front();
            ts = typed_status_q.pop_front();
            tc = typed_count_q.pop_front();
            if (ty && (ts !== rsp_status || tc !== rsp_entry_count)) begin
               $display("%0t: table row: expected status=%0d count=%0d, got %0d %0d",
                        $time, ts, tc, rsp_status, rsp_entry_count);
               errors++;
            end
            if (e.status !== rsp_status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status,
                        rsp_status);
               errors++;
            end
            if (e.removed !== rsp_removed_value) begin
               $display("%0t: removed expected %h actual %h", $time, e.removed,
                        rsp_removed_value);
               errors++;
            end
            if (e.found !== rsp_found) begin
               $display("%0t: found expected %0d actual %0d", $time, e.found, rsp_found);
               errors++;
            end
            if (e.count !== rsp_entry_count) begin
               $display("%0t: count expected %0d actual %0d", $time, e.count,
                        rsp_entry_count);
               errors++;
            end
            if (e.front !== rsp_front_value) begin
               $display("%0t: front expected %h actual %h", $time, e.front,
                        rsp_front_value);
               errors++;
            end
            if (e.back !== rsp_back_value) begin
               $display("%0t: back expected %h actual %h", $time, e.back,
                        rsp_back_value);
               errors++;
            end
         end
      end
   end

   cmd_row_type directed [] = '{
      '{OP_POP_FRONT,  32'h0,         32'h0,         1, ST_EMPTY,     7'd0},
      '{OP_POP_BACK,   32'h0,         32'h0,         1, ST_EMPTY,     7'd0},
      '{OP_DELETE,     32'h0,         32'h5,         1, ST_EMPTY,     7'd0},
      '{OP_SEARCH,     32'h0,         32'h0,         1, ST_OK,        7'd0},
      '{OP_INS_AFTER,  32'h8000_0000, 32'h1234,      1, ST_OK,        7'd1},
      '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 32'h0,         1, ST_OK,        7'd2},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK,        7'd3},
      '{OP_INS_AFTER,  32'h0000_0011, 32'h5555_5555, 1, ST_NOT_FOUND, 7'd3},
      '{OP_INS_AFTER,  32'h0000_0022, 32'hFFFF_FFFF, 0, ST_OK,        7'd0},
      '{OP_INS_AFTER,  32'h0000_0033, 32'h7FFF_FFFF, 0, ST_OK,        7'd0},
      '{OP_SEARCH,     32'h0000_0022, 32'h0,         0, ST_OK,        7'd0},
      '{OP_SEARCH,     32'h1111_1111, 32'h0,         0, ST_OK,        7'd0},
      '{OP_NONE,       32'hAAAA_AAAA, 32'h5555_5555, 0, ST_OK,        7'd0},
      '{OP_DELETE,     32'h0,         32'h5555_5555, 1, ST_NOT_FOUND, 7'd5},
      '{OP_DELETE,     32'h0,         32'h0000_0022, 0, ST_OK,        7'd0},
      '{OP_DELETE,     32'h0,         32'h7FFF_FFFF, 0, ST_OK,        7'd0},
      '{OP_POP_BACK,   32'h0,         32'h0,         0, ST_OK,        7'd0},
      '{OP_POP_FRONT,  32'h0,         32'h0,         0, ST_OK,        7'd0},
      '{OP_POP_BACK,   32'h0,         32'h0,         0, ST_OK,        7'd0},
      '{OP_POP_FRONT,  32'h0,         32'h0,         1, ST_EMPTY,     7'd0}
   };

   initial begin
      for (int i = 0; i < Cap; i++) begin
         vals[i] = '0;
         links[i] = 6'((i + 1) % Cap);
      end
      head_n = 0; tail_n = 0; free_n = 0; occ = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (directed[i])
         send_cmd(directed[i].op, directed[i].item, directed[i].point,
                  directed[i].typed, directed[i].status, directed[i].count);
      // fill to capacity, hit the full cases, then pop one from the back
      while (occ < Cap) send_cmd(OP_PUSH_BACK, $urandom, 0, 0, 0, 0);
      send_cmd(OP_PUSH_FRONT, 32'h1, 0, 1, ST_FULL, 7'd64);
      send_cmd(OP_INS_AFTER, 32'h2, pick_value(), 1, ST_FULL, 7'd64);
      send_cmd(OP_POP_BACK, 0, 0, 0, 0, 0);
      // random part: phases biased toward growing or shrinking, or unbiased
      while (rnd_count < NumRandom) begin
         int grow;
         grow = $urandom_range(0, 2);
         repeat ($urandom_range(10, 60)) begin
            opcode_type op;
            int k;
            k = $urandom_range(0, 99);
            if (grow == 2) op = opcode_type'(k < 35 ? OP_PUSH_FRONT : k < 65 ? OP_PUSH_BACK :
                                k < 85 ? OP_INS_AFTER : $urandom_range(3, 7));
            else if (grow == 0) op = opcode_type'(k < 30 ? OP_POP_FRONT : k < 60 ? OP_POP_BACK :
                                     k < 85 ? OP_DELETE : $urandom_range(0, 7));
            else op = opcode_type'($urandom_range(0, 7));
            send_cmd(op, pick_value(), pick_value(), 0, 0, 0);
            rnd_count++;
         end
      end
      while (pending_results.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
design/bcle_pkg.sv
design/bcle_ctrl.sv
design/bcle_dp.sv
design/bounded_circular_list_engine.sv
tb/sv/testbench.sv
